FILE: hdl/ship_rrip_replacement_top_defines.svh
// Assertion macros used by the replacement engine sequencer.
`ifndef SHIP_RRIP_REPLACEMENT_TOP_DEFINES_SVH
`define SHIP_RRIP_REPLACEMENT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SHIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHIP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SHIP_ASSERT(lbl, clk, rst, prop, msg)
`define SHIP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: hdl/ship_rrip_pkg.sv
// Types, sizes and command codes of the SHiP/SRRIP replacement engine.
`default_nettype none
package ship_rrip_pkg;

   // store geometry
   localparam int SETS            = 2048;
   localparam int WAYS            = 16;
   localparam int COUNTER_ENTRIES = 4096;
   localparam int RRPV_WIDTH      = 3;
   localparam int COUNTER_WIDTH   = 3;

   // transaction field widths
   localparam int FUNC_W      = 1;
   localparam int SET_INDEX_W = 11;
   localparam int WAY_W       = 4;
   localparam int PC_W        = 64;
   localparam int THRESH_W    = 3;

   localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_AW  = $clog2(WAYS);
   localparam int SIG_W   = $clog2(COUNTER_ENTRIES);
   localparam int SWEEP_N = (SETS > COUNTER_ENTRIES) ? SETS : COUNTER_ENTRIES;
   localparam int CLR_W   = $clog2(SWEEP_N);

   localparam logic [RRPV_WIDTH-1:0]    RRPV_TOP  = {RRPV_WIDTH{1'b1}};
   localparam logic [RRPV_WIDTH-1:0]    RRPV_NEAR = RRPV_TOP - RRPV_WIDTH'(1);
   localparam logic [COUNTER_WIDTH-1:0] CTR_TOP   = {COUNTER_WIDTH{1'b1}};
   localparam logic [COUNTER_WIDTH-1:0] CTR_START = CTR_TOP >> 1;
   localparam logic [THRESH_W-1:0]      THRESH_RESET = THRESH_W'(3);

   // func codes
   localparam logic [FUNC_W-1:0] FUNC_VICTIM = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

   // row write operations
   localparam logic [1:0] ROW_OP_CLEAR = 2'd0;
   localparam logic [1:0] ROW_OP_AGE   = 2'd1;
   localparam logic [1:0] ROW_OP_HIT   = 2'd2;
   localparam logic [1:0] ROW_OP_FILL  = 2'd3;

   // counter write operations
   localparam logic [1:0] CTR_OP_CLEAR = 2'd0;
   localparam logic [1:0] CTR_OP_INC   = 2'd1;
   localparam logic [1:0] CTR_OP_DEC   = 2'd2;

   typedef struct packed {
      logic [RRPV_WIDTH-1:0] rrpv;
      logic                  reused;
      logic [SIG_W-1:0]      sig;
   } way_entry_type;

   typedef way_entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic             latch_req;
      logic             row_rd;
      logic             row_wr;
      logic [1:0]       row_op;
      logic             ctr_rd;
      logic             ctr_rd_new;
      logic             ctr_wr;
      logic [1:0]       ctr_op;
      logic             load_rsp;
      logic [CLR_W-1:0] clr_idx;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              hit;
      logic              way_ok;
   } sts_type;

endpackage
`default_nettype wire

FILE: hdl/ship_rrip_ifs.sv
// Request and response channel interfaces of the replacement engine.
`default_nettype none
interface ship_rrip_req_if import ship_rrip_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [SET_INDEX_W-1:0] set_index;
   logic [WAY_W-1:0]       way;
   logic                   hit;
   logic [PC_W-1:0]        pc;

   modport source (output valid, func, set_index, way, hit, pc, input ready);
   modport sink   (input valid, func, set_index, way, hit, pc, output ready);
endinterface

interface ship_rrip_rsp_if import ship_rrip_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WAY_W-1:0] victim_way;

   modport source (output valid, victim_way, input ready);
   modport sink   (input valid, victim_way, output ready);
endinterface
`default_nettype wire

FILE: hdl/ship_rrip_ctrl.sv
// Sequencer of the replacement engine: clearing sweep and per-transaction steps.
`default_nettype none
`include "ship_rrip_replacement_top_defines.svh"
module ship_rrip_ctrl import ship_rrip_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] ST_CLEAR      = 3'd0;
   localparam logic [2:0] ST_IDLE       = 3'd1;
   localparam logic [2:0] ST_ROW_RD     = 3'd2;
   localparam logic [2:0] ST_EVAL       = 3'd3;
   localparam logic [2:0] ST_CTR_OLD    = 3'd4;
   localparam logic [2:0] ST_CTR_NEW_RD = 3'd5;
   localparam logic [2:0] ST_CTR_NEW    = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CLR_W-1:0] clr_idx_ff, clr_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      cmd            = '0;
      cmd.clr_idx    = clr_idx_ff;
      cmd.row_op     = ROW_OP_CLEAR;
      cmd.ctr_op     = CTR_OP_CLEAR;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.row_wr = ({1'b0, clr_idx_ff} < (CLR_W+1)'(SETS));
            cmd.ctr_wr = ({1'b0, clr_idx_ff} < (CLR_W+1)'(COUNTER_ENTRIES));
            if (clr_idx_ff == CLR_W'(SWEEP_N - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + CLR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.func == FUNC_VICTIM) begin
               if (rsp_free) begin
                  cmd.row_wr   = 1'b1;
                  cmd.row_op   = ROW_OP_AGE;
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (!sts.way_ok) begin
               if (rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.ctr_rd = 1'b1;
               state_in   = ST_CTR_OLD;
            end
         end
         ST_CTR_OLD: begin
            if (sts.hit) begin
               if (rsp_free) begin
                  cmd.ctr_wr   = 1'b1;
                  cmd.ctr_op   = CTR_OP_INC;
                  cmd.row_wr   = 1'b1;
                  cmd.row_op   = ROW_OP_HIT;
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.ctr_wr = 1'b1;
               cmd.ctr_op = CTR_OP_DEC;
               state_in   = ST_CTR_NEW_RD;
            end
         end
         ST_CTR_NEW_RD: begin
            cmd.ctr_rd     = 1'b1;
            cmd.ctr_rd_new = 1'b1;
            state_in       = ST_CTR_NEW;
         end
         ST_CTR_NEW: begin
            if (rsp_free) begin
               cmd.row_wr   = 1'b1;
               cmd.row_op   = ROW_OP_FILL;
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SHIP_ASSERT_NEVER(a_rsp_no_overwrite, clock, reset, cmd.load_rsp && rsp_valid_ff && !rsp_ready, "response overwritten before it was taken")
   `SHIP_ASSERT(a_accept_reads_row, clock, reset, req_valid && req_ready |=> state_ff == ST_ROW_RD, "accepted transaction did not start a row read")
   `SHIP_ASSERT(a_load_shows_rsp, clock, reset, cmd.load_rsp |=> rsp_valid_ff, "loaded response not presented")

endmodule
`default_nettype wire

FILE: hdl/ship_rrip_dp.sv
// Datapath of the replacement engine: set and counter memories, victim and update logic.
`default_nettype none
module ship_rrip_dp import ship_rrip_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [FUNC_W-1:0]      req_func,
   input  wire logic [SET_INDEX_W-1:0] req_set_index,
   input  wire logic [WAY_W-1:0]       req_way,
   input  wire logic                   req_hit,
   input  wire logic [PC_W-1:0]        req_pc,
   input  wire logic                   csr_wr_en,
   input  wire logic [THRESH_W-1:0]    csr_wr_data,
   output logic [WAY_W-1:0]            rsp_victim_way
);

   localparam int CMP_W = (COUNTER_WIDTH > THRESH_W) ? COUNTER_WIDTH : THRESH_W;

   row_type                  row_mem_ff [SETS];
   logic [COUNTER_WIDTH-1:0] ctr_mem_ff [COUNTER_ENTRIES];

   logic [FUNC_W-1:0]        func_ff;
   logic [SET_AW-1:0]        set_ff;
   logic [WAY_AW-1:0]        way_ff;
   logic                     way_ok_ff;
   logic                     hit_ff;
   logic [SIG_W-1:0]         nsig_ff;
   logic [THRESH_W-1:0]      thresh_ff;
   row_type                  row_q_ff;
   logic [COUNTER_WIDTH-1:0] ctr_q_ff;
   logic [WAY_W-1:0]         victim_ff;

   logic [RRPV_TOP:0]        level_seen;
   logic [RRPV_WIDTH-1:0]    max_rrpv;
   logic [RRPV_WIDTH-1:0]    age_add;
   logic [WAYS-1:0]          max_mask;
   logic [WAYS-1:0]          first_mask;
   logic [WAY_AW-1:0]        vic_idx;
   logic [RRPV_WIDTH-1:0]    ins_rrpv;
   way_entry_type            old_entry;
   row_type                  row_wdata;
   logic [SET_AW-1:0]        row_waddr;
   logic [SIG_W-1:0]         ctr_waddr;
   logic [SIG_W-1:0]         ctr_raddr;
   logic [COUNTER_WIDTH-1:0] ctr_wdata;

   assign sts.func   = func_ff;
   assign sts.hit    = hit_ff;
   assign sts.way_ok = way_ok_ff;

   // request capture and threshold register
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff   <= req_func;
         set_ff    <= SET_AW'(req_set_index);
         way_ff    <= WAY_AW'(req_way);
         way_ok_ff <= ({1'b0, req_way} < (WAY_W+1)'(WAYS));
         hit_ff    <= req_hit;
         nsig_ff   <= req_pc[SIG_W+1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // victim search: highest RRPV present, then lowest way holding it
   always_comb begin
      for (int v = 0; v <= RRPV_TOP; v++) begin
         level_seen[v] = 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            level_seen[v] = level_seen[v] | (row_q_ff[w].rrpv == RRPV_WIDTH'(v));
         end
      end
      max_rrpv = '0;
      for (int v = 0; v <= RRPV_TOP; v++) begin
         if (level_seen[v]) begin
            max_rrpv = RRPV_WIDTH'(v);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         max_mask[w] = (row_q_ff[w].rrpv == max_rrpv);
      end
      first_mask = max_mask & (~max_mask + WAYS'(1));
      vic_idx    = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (first_mask[w]) begin
            vic_idx = vic_idx | WAY_AW'(w);
         end
      end
   end

   assign age_add   = RRPV_TOP - max_rrpv;
   assign old_entry = row_q_ff[way_ff];

   // insertion position from the new signature's counter
   always_comb begin
      if (CMP_W'(ctr_q_ff) > CMP_W'(thresh_ff)) begin
         ins_rrpv = '0;
      end else if (ctr_q_ff == '0) begin
         ins_rrpv = RRPV_TOP;
      end else begin
         ins_rrpv = RRPV_NEAR;
      end
   end

   always_comb begin
      row_wdata = row_q_ff;
      unique case (cmd.row_op)
         ROW_OP_CLEAR: begin
            for (int w = 0; w < WAYS; w++) begin
               row_wdata[w].rrpv   = RRPV_TOP;
               row_wdata[w].reused = 1'b0;
               row_wdata[w].sig    = '0;
            end
         end
         ROW_OP_AGE: begin
            for (int w = 0; w < WAYS; w++) begin
               row_wdata[w].rrpv = row_q_ff[w].rrpv + age_add;
            end
         end
         ROW_OP_HIT: begin
            row_wdata[way_ff].rrpv   = '0;
            row_wdata[way_ff].reused = 1'b1;
         end
         ROW_OP_FILL: begin
            row_wdata[way_ff].rrpv   = ins_rrpv;
            row_wdata[way_ff].reused = 1'b0;
            row_wdata[way_ff].sig    = nsig_ff;
         end
         default: begin
            row_wdata = row_q_ff;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.ctr_op)
         CTR_OP_INC: begin
            ctr_wdata = (ctr_q_ff == CTR_TOP) ? ctr_q_ff : ctr_q_ff + COUNTER_WIDTH'(1);
         end
         CTR_OP_DEC: begin
            // train down only for a block that never saw a hit
            ctr_wdata = (old_entry.reused || ctr_q_ff == '0) ?
                        ctr_q_ff : ctr_q_ff - COUNTER_WIDTH'(1);
         end
         default: begin
            ctr_wdata = CTR_START;
         end
      endcase
   end

   assign row_waddr = (cmd.row_op == ROW_OP_CLEAR) ? SET_AW'(cmd.clr_idx) : set_ff;
   assign ctr_waddr = (cmd.ctr_op == CTR_OP_CLEAR) ? SIG_W'(cmd.clr_idx) : old_entry.sig;
   assign ctr_raddr = cmd.ctr_rd_new ? nsig_ff : old_entry.sig;

   always_ff @(posedge clock) begin
      if (cmd.row_wr) begin
         row_mem_ff[row_waddr] <= row_wdata;
      end
      if (cmd.row_rd) begin
         row_q_ff <= row_mem_ff[set_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ctr_wr) begin
         ctr_mem_ff[ctr_waddr] <= ctr_wdata;
      end
      if (cmd.ctr_rd) begin
         ctr_q_ff <= ctr_mem_ff[ctr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         victim_ff <= (func_ff == FUNC_VICTIM) ? WAY_W'(vic_idx) : '0;
      end
   end

   assign rsp_victim_way = victim_ff;

endmodule
`default_nettype wire

FILE: hdl/ship_rrip_replacement_top.sv
// Steps: row read and evaluate; updates then train the old counter, fills read the new one.
// One transaction is in flight at a time; the next is accepted in the cycle after the
// response is loaded, even while that response still waits; set the pace by the single
// read/write port of each memory (set row memory, reuse counter memory).
// Reset: a clearing sweep rewrites every set row and every counter, with
// req_chan.ready low; csr writes are taken throughout.
`default_nettype none
module ship_rrip_replacement_top import ship_rrip_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   ship_rrip_req_if.sink            req_chan,
   ship_rrip_rsp_if.source          rsp_chan,
   input  wire logic                csr_wr_en,
   input  wire logic [THRESH_W-1:0] csr_wr_data
);

   // command and status between the sequencer and the datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: clearing sweep, then row read, evaluate, counter train, row write
   ship_rrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: memories, victim search, aging, insertion choice, response register
   ship_rrip_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_chan.func),
      .req_set_index  (req_chan.set_index),
      .req_way        (req_chan.way),
      .req_hit        (req_chan.hit),
      .req_pc         (req_chan.pc),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_victim_way (rsp_chan.victim_way)
   );

endmodule
`default_nettype wire

FILE: verif/tb_ship_rrip_replacement_top.sv
// Self-checking testbench for the SHiP/SRRIP replacement engine top level.
`default_nettype none
module tb_ship_rrip_replacement_top import ship_rrip_pkg::*; ();

   // One request transaction as it travels on req_chan.
   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [SET_INDEX_W-1:0] set_index;
      logic [WAY_W-1:0]       way;
      logic                   hit;
      logic [PC_W-1:0]        pc;
   } access_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;

   ship_rrip_req_if req_chan();
   ship_rrip_rsp_if rsp_chan();

   ship_rrip_replacement_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the engine state: per-way RRPV, reused flag and fill signature,
   // plus the signature-indexed reuse counters and the threshold register.
   logic [RRPV_WIDTH-1:0]    rrpv_mirror      [SETS][WAYS];
   logic                     reused_mirror    [SETS][WAYS];
   logic [SIG_W-1:0]         sig_mirror       [SETS][WAYS];
   logic [COUNTER_WIDTH-1:0] reuse_ctr_mirror [COUNTER_ENTRIES];
   logic [THRESH_W-1:0]      threshold_mirror;

   // Victim ways still owed by the engine, oldest first.
   logic [WAY_W-1:0] expected_victims [$];

   int unsigned mismatch_count = 0;
   bit          idle_en        = 1'b1;
   bit          rsp_holding    = 1'b0;
   int unsigned hold_len       = 0;
   event        hold_go;

   // Small pools that keep the random traffic on a few sets and signatures,
   // so rows fill up, age and counters travel between both rails.
   logic [SET_INDEX_W-1:0] hot_sets [4];
   logic [PC_W-1:0]        hot_pcs  [6];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the engine hangs on a handshake.
   initial begin : run_limit
      #2000000;
      $display("[ship_rrip_replacement_top] ERROR");
      $finish;
   end

   // Apply one accepted transaction to the mirror and return the victim way
   // the engine must answer with (zero for updates).
   function automatic logic [WAY_W-1:0] apply_access_to_mirror(access_type a);
      int                       s;
      int                       w;
      logic [RRPV_WIDTH-1:0]    top;
      logic [RRPV_WIDTH-1:0]    lift;
      logic [SIG_W-1:0]         old_sig;
      logic [SIG_W-1:0]         new_sig;
      logic [COUNTER_WIDTH-1:0] ctr;
      logic [WAY_W-1:0]         pick;
      s = int'(a.set_index) % SETS;
      if (a.func == FUNC_VICTIM) begin
         // Age the whole row just far enough that its oldest way hits the top.
         top = '0;
         for (w = 0; w < WAYS; w++)
            if (rrpv_mirror[s][w] > top) top = rrpv_mirror[s][w];
         lift = RRPV_TOP - top;
         for (w = 0; w < WAYS; w++)
            rrpv_mirror[s][w] = rrpv_mirror[s][w] + lift;
         // Scan downward so the lowest-numbered distant way wins.
         pick = '0;
         for (w = WAYS - 1; w >= 0; w--)
            if (rrpv_mirror[s][w] == RRPV_TOP) pick = WAY_W'(w);
         return pick;
      end
      w = int'(a.way);
      if (w >= WAYS) return '0;
      old_sig = sig_mirror[s][w];
      if (a.hit) begin
         // Promote the way and train its signature toward reuse.
         rrpv_mirror[s][w]   = '0;
         reused_mirror[s][w] = 1'b1;
         if (reuse_ctr_mirror[old_sig] != CTR_TOP)
            reuse_ctr_mirror[old_sig] = reuse_ctr_mirror[old_sig] + 1'b1;
      end else begin
         // Penalize the evicted block only if it was never reused.
         if (!reused_mirror[s][w] && reuse_ctr_mirror[old_sig] != '0)
            reuse_ctr_mirror[old_sig] = reuse_ctr_mirror[old_sig] - 1'b1;
         new_sig             = a.pc[SIG_W+1:2];
         sig_mirror[s][w]    = new_sig;
         reused_mirror[s][w] = 1'b0;
         ctr                 = reuse_ctr_mirror[new_sig];
         if (ctr > threshold_mirror)
            rrpv_mirror[s][w] = '0;
         else if (ctr == '0)
            rrpv_mirror[s][w] = RRPV_TOP;
         else
            rrpv_mirror[s][w] = RRPV_NEAR;
      end
      return '0;
   endfunction

   function automatic logic [SET_INDEX_W-1:0] draw_set();
      if ($urandom_range(0, 99) < 75) return hot_sets[$urandom_range(0, 3)];
      return SET_INDEX_W'($urandom_range(0, 2047));
   endfunction

   function automatic logic [PC_W-1:0] draw_pc();
      if ($urandom_range(0, 99) < 75) return hot_pcs[$urandom_range(0, 5)];
      return {$urandom, $urandom};
   endfunction

   // Offer one transaction after a random gap, hold it until the engine takes
   // it, then record the expected victim. Leave valid high on return so a
   // back-to-back transaction needs no second assignment in the same step.
   task automatic send_access(input access_type a, output logic [WAY_W-1:0] predicted);
      int unsigned gap;
      gap = idle_en ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= a.func;
      req_chan.set_index <= a.set_index;
      req_chan.way       <= a.way;
      req_chan.hit       <= a.hit;
      req_chan.pc        <= a.pc;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = apply_access_to_mirror(a);
      expected_victims.push_back(predicted);
   endtask

   task automatic issue_access(input logic [FUNC_W-1:0] f, input logic [SET_INDEX_W-1:0] s,
                               input logic [WAY_W-1:0] w, input logic h,
                               input logic [PC_W-1:0] pc);
      access_type       a;
      logic [WAY_W-1:0] ignored;
      a.func      = f;
      a.set_index = s;
      a.way       = w;
      a.hit       = h;
      a.pc        = pc;
      send_access(a, ignored);
   endtask

   // Drop valid, wait for every owed response, then let the fill write-back
   // of the last transaction settle.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_victims.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      threshold_mirror = value;
      csr_wr_en <= 1'b0;
   endtask

   // Fresh rows are all distant, so the first victim is always way 0.
   task automatic test_reset_state();
      issue_access(FUNC_VICTIM, '0, '0, 1'b0, '0);
      issue_access(FUNC_VICTIM, '1, '1, 1'b1, '1);
   endtask

   // Hit every way of one set: the shared signature counter saturates at its
   // top, and the next victim request must age the whole row back to distant.
   task automatic test_hit_saturation_and_aging();
      for (int w = 0; w < WAYS; w++)
         issue_access(FUNC_UPDATE, SET_INDEX_W'(1), WAY_W'(w), 1'b1, 64'h0);
      issue_access(FUNC_VICTIM, SET_INDEX_W'(1), '0, 1'b0, '0);
      issue_access(FUNC_VICTIM, SET_INDEX_W'(1), '0, 1'b0, '0);
   endtask

   // Fills: hot signature inserts near, neutral one inserts intermediate,
   // and a never-reused eviction trains its signature down.
   task automatic test_fill_insertion();
      issue_access(FUNC_UPDATE, SET_INDEX_W'(1), WAY_W'(3), 1'b0, 64'h0);
      issue_access(FUNC_UPDATE, SET_INDEX_W'(1), '1, 1'b0, '1);
      issue_access(FUNC_UPDATE, '1, '0, 1'b0, 64'hFFFF_FFFF_FFFF_C003);
      issue_access(FUNC_VICTIM, SET_INDEX_W'(1), '1, 1'b1, '1);
   endtask

   // Cache-like traffic in phases, one threshold setting per phase: mostly
   // hits and victim-then-fill pairs, with some stray requests as noise.
   task automatic test_random_traffic();
      int               sent;
      int unsigned      pick;
      access_type       a;
      logic [WAY_W-1:0] victim;
      hot_sets[0] = '0;
      hot_sets[1] = '1;
      hot_sets[2] = SET_INDEX_W'($urandom_range(2, 2046));
      hot_sets[3] = SET_INDEX_W'($urandom_range(2, 2046));
      foreach (hot_pcs[i]) hot_pcs[i] = {$urandom, $urandom};
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_threshold(THRESH_W'(7));
            end
            1: begin
               write_threshold(THRESH_W'(0));
            end
            default: begin
               write_threshold(THRESH_W'($urandom_range(1, 6)));
            end
         endcase
         // Run the second phase flat out on both sides.
         idle_en = (phase != 1);
         sent    = 0;
         while (sent < 300) begin
            pick        = $urandom_range(0, 99);
            a.set_index = draw_set();
            a.way       = WAY_W'($urandom_range(0, WAYS - 1));
            a.hit       = 1'($urandom_range(0, 1));
            a.pc        = draw_pc();
            if (pick < 40) begin
               a.func = FUNC_UPDATE;
               a.hit  = 1'b1;
               send_access(a, victim);
               sent += 1;
            end else if (pick < 85) begin
               // Miss: ask for the victim, then fill exactly that way.
               a.func = FUNC_VICTIM;
               send_access(a, victim);
               a.func = FUNC_UPDATE;
               a.way  = victim;
               a.hit  = 1'b0;
               a.pc   = draw_pc();
               send_access(a, victim);
               sent += 2;
            end else begin
               a.func = 1'($urandom_range(0, 1));
               a.hit  = 1'b0;
               send_access(a, victim);
               sent += 1;
            end
         end
      end
      idle_en = 1'b1;
   endtask

   // Hold the response side off for a long stretch while requests keep
   // coming, so the engine fills its output and stalls its input.
   task automatic test_response_backpressure();
      wait_idle();
      hold_len = 300;
      -> hold_go;
      idle_en = 1'b0;
      for (int i = 0; i < 8; i++)
         issue_access(1'($urandom_range(0, 1)), draw_set(), WAY_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), draw_pc());
      idle_en = 1'b1;
   endtask

   // Long hold counted in cycles; the response side polls rsp_holding.
   initial begin : response_hold
      forever begin
         @(hold_go);
         rsp_holding = 1'b1;
         repeat (hold_len) @(posedge clock);
         rsp_holding = 1'b0;
      end
   end

   // Accept responses after a random stall and check each against the oldest
   // owed victim way.
   initial begin : response_checker
      int unsigned      stall;
      logic [WAY_W-1:0] want;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_en ? $urandom_range(0, 19) : 0;
         if (stall > 0 || rsp_holding) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_holding) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         if (expected_victims.size() == 0) begin
            $error("unexpected response: victim_way actual %0d", rsp_chan.victim_way);
            mismatch_count++;
         end else begin
            want = expected_victims.pop_front();
            if (rsp_chan.victim_way !== want) begin
               $error("victim_way mismatch: expected %0d actual %0d",
                      want, rsp_chan.victim_way);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : test_sequence
      // Drive every input to a known value before the first edge.
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.func      <= FUNC_VICTIM;
      req_chan.set_index <= '0;
      req_chan.way       <= '0;
      req_chan.hit       <= 1'b0;
      req_chan.pc        <= '0;
      // Mirror starts from the cleared state the reset sweep leaves behind.
      for (int s = 0; s < SETS; s++)
         for (int w = 0; w < WAYS; w++) begin
            rrpv_mirror[s][w]   = RRPV_TOP;
            reused_mirror[s][w] = 1'b0;
            sig_mirror[s][w]    = '0;
         end
      for (int i = 0; i < COUNTER_ENTRIES; i++) reuse_ctr_mirror[i] = CTR_START;
      threshold_mirror = THRESH_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The engine keeps ready low through its clearing sweep; the first
      // transaction simply waits for it.
      test_reset_state();
      test_hit_saturation_and_aging();
      test_fill_insertion();
      test_random_traffic();
      test_response_backpressure();
      wait_idle();

      if (mismatch_count == 0)
         $display("[ship_rrip_replacement_top] OK");
      else
         $display("[ship_rrip_replacement_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/ship_rrip_pkg.sv
hdl/ship_rrip_ifs.sv
hdl/ship_rrip_ctrl.sv
hdl/ship_rrip_dp.sv
hdl/ship_rrip_replacement_top.sv
verif/tb_ship_rrip_replacement_top.sv
